### rtl/pfc_pkg.sv
// Shared types and constants for the prime frequency counter.
package pfc_pkg;

  localparam int VALUE_W       = 32;
  localparam int PRIME_W       = 31;
  localparam int COUNT_W       = 16;
  localparam int DIV_W         = 16;
  localparam int SQ_W          = 32;
  localparam int TABLE_DEPTH_D = 32;
  localparam int MIN_PRIME     = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } in_item_t;

  typedef struct packed {
    logic [PRIME_W-1:0] prime;
    logic [COUNT_W-1:0] count;
    logic               final_res;
    logic               overflowed;
  } out_item_t;

  typedef struct packed {
    logic [PRIME_W-1:0] prime;
    logic [COUNT_W-1:0] count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### rtl/prime_frequency_counter_core.sv
// Prime frequency counter: primality test, first-seen table in RAM, result readout.
//
// Each item's value is tested by trial division; a pipelined remainder array takes one
// divisor per cycle, and a composite stops at its smallest factor. Negative values and
// values below two finish without entering the array. A prime then searches the table
// RAM entry by entry, a read and a compare step per stored entry, then updates the
// matching count or appends a new entry, setting the overflow flag if the table is full.
// The block takes one item at a time and holds in_stall high while it works. On an item
// marked last it streams one result per table entry, in first-seen order, then clears
// the table and the overflow flag. No clearing pass is needed after reset.
module prime_frequency_counter_core import pfc_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_D
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_TEST   = 9'b000000010,
    S_SRD    = 9'b000000100,
    S_SCMP   = 9'b000001000,
    S_APPEND = 9'b000010000,
    S_FIN    = 9'b000100000,
    S_ERD    = 9'b001000000,
    S_ELOAD  = 9'b010000000,
    S_EOUT   = 9'b100000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      used_r, used_nxt;
  logic               ovf_r, ovf_nxt;
  logic [PRIME_W-1:0] p_r, p_nxt;
  logic               last_r, last_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               t_start;
  logic               t_done;
  logic               t_prime;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  entry_t             ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_ent;
  logic               idx_is_tail;

  pfc_prime_test u_test (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (t_start),
    .value    (in_data.value),
    .done     (t_done),
    .is_prime (t_prime)
  );

  pfc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_ent      = entry_t'(ram_rdata);
  assign idx_is_tail = (CW'(idx_r) + CW'(1)) == used_r;
  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    used_nxt      = used_r;
    ovf_nxt       = ovf_r;
    p_nxt         = p_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    t_start       = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          t_start   = 1'b1;
          p_nxt     = in_data.value[PRIME_W-1:0];
          last_nxt  = in_data.last;
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (t_done) begin
          if (!t_prime) begin
            state_nxt = S_FIN;
          end else if (used_r == '0) begin
            state_nxt = S_APPEND;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_SRD;
          end
        end
      end
      S_SRD: begin
        ram_re    = 1'b1;
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        if (rd_ent.prime == p_r) begin
          ram_we          = 1'b1;
          ram_wdata.prime = p_r;
          ram_wdata.count = (rd_ent.count == COUNT_MAX) ? COUNT_MAX
                                                         : rd_ent.count + COUNT_W'(1);
          state_nxt       = S_FIN;
        end else if (idx_is_tail) begin
          state_nxt = S_APPEND;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_SRD;
        end
      end
      S_APPEND: begin
        if (used_r < CW'(TABLE_DEPTH)) begin
          ram_we          = 1'b1;
          ram_waddr       = used_r[AW-1:0];
          ram_wdata.prime = p_r;
          ram_wdata.count = COUNT_W'(1);
          used_nxt        = used_r + CW'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (used_r == '0) begin
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_ERD;
        end
      end
      S_ERD: begin
        ram_re    = 1'b1;
        state_nxt = S_ELOAD;
      end
      S_ELOAD: begin
        out_data_nxt.prime      = rd_ent.prime;
        out_data_nxt.count      = rd_ent.count;
        out_data_nxt.final_res  = idx_is_tail;
        out_data_nxt.overflowed = ovf_r;
        out_valid_nxt           = 1'b1;
        state_nxt               = S_EOUT;
      end
      S_EOUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_data_r.final_res) begin
            used_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    p_r        <= p_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(TABLE_DEPTH))
    else $error("table fill count above depth");

  a_out_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (used_r != '0))
    else $error("result shown from an empty table");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && out_data_r.final_res) |=> (used_r == '0) && !ovf_r)
    else $error("table not cleared after final result");

  a_accept_tests: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_TEST) && !out_valid_r)
    else $error("accepted item did not enter the primality test");

endmodule

### rtl/pfc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/pfc_prime_test.sv
// Primality test by trial division through a pipelined remainder array.
module pfc_prime_test import pfc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [VALUE_W-1:0] value,
  output logic               done,
  output logic               is_prime
);

  localparam int NB = PRIME_W;

  logic               busy_r;
  logic               issuing_r;
  logic [NB-1:0]      n_r;
  logic [DIV_W-1:0]   d_r;
  logic [SQ_W-1:0]    sq_r;
  logic [NB-1:0]      vld_r;
  logic [NB-1:0]      vld_nxt;
  logic [DIV_W-1:0]   rem_r   [NB];
  logic [DIV_W-1:0]   rem_nxt [NB];
  logic [DIV_W-1:0]   dv_r    [NB];
  logic [DIV_W-1:0]   dv_nxt  [NB];
  logic               done_r;
  logic               prime_r;
  logic               issue;
  logic               hit;

  always_comb begin
    logic [DIV_W-1:0] rin;
    logic [DIV_W-1:0] din;
    logic [DIV_W:0]   t;
    issue = busy_r && issuing_r && (sq_r <= SQ_W'(n_r));
    for (int k = 0; k < NB; k++) begin
      if (k == 0) begin
        rin        = '0;
        din        = d_r;
        vld_nxt[k] = issue;
      end else begin
        rin        = rem_r[k-1];
        din        = dv_r[k-1];
        vld_nxt[k] = vld_r[k-1];
      end
      t = {rin, n_r[NB-1-k]};
      if (t >= {1'b0, din}) begin
        rem_nxt[k] = DIV_W'(t - {1'b0, din});
      end else begin
        rem_nxt[k] = t[DIV_W-1:0];
      end
      dv_nxt[k] = din;
    end
    hit = vld_r[NB-1] && (rem_r[NB-1] == '0);
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      issuing_r <= 1'b0;
      vld_r     <= '0;
      done_r    <= 1'b0;
      prime_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (value[VALUE_W-1] || (value[NB-1:0] < NB'(MIN_PRIME))) begin
          done_r  <= 1'b1;
          prime_r <= 1'b0;
        end else begin
          busy_r    <= 1'b1;
          issuing_r <= 1'b1;
          n_r       <= value[NB-1:0];
          d_r       <= DIV_W'(MIN_PRIME);
          sq_r      <= SQ_W'(MIN_PRIME * MIN_PRIME);
          vld_r     <= '0;
        end
      end else if (busy_r) begin
        if (hit) begin
          busy_r  <= 1'b0;
          done_r  <= 1'b1;
          prime_r <= 1'b0;
          vld_r   <= '0;
        end else if (!issuing_r && (vld_r == '0)) begin
          busy_r  <= 1'b0;
          done_r  <= 1'b1;
          prime_r <= 1'b1;
        end else begin
          vld_r     <= vld_nxt;
          issuing_r <= issue;
          if (issue) begin
            d_r  <= d_r + DIV_W'(1);
            sq_r <= sq_r + SQ_W'({d_r, 1'b1});
          end
        end
      end
    end
  end

  assign done     = done_r;
  assign is_prime = prime_r;

endmodule
